// ===== hw/rtl/swq_pkg.sv =====
// Shared types and constants for the sorted wake-up queue.
// No dependencies.
package swq_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int POP_W       = $clog2(MAX_RESULTS + 1);
  localparam int TICK_W      = 63;
  localparam int WAKE_W      = 64;
  localparam logic [WAKE_W-1:0] BIAS = 64'h0000_0000_8000_0000;
  localparam logic [31:0] BIAS32 = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_WOKEN    = 2'd2,
    ST_NONE     = 2'd3
  } swq_status_t;

  typedef struct packed {
    logic [WAKE_W-1:0] wake;
    logic [7:0]        id;
  } swq_entry_t;

  localparam int ENTRY_W = $bits(swq_entry_t);

endpackage

// ===== hw/rtl/swq_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module swq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/sorted_wakeup_queue.sv =====
// Sorted wake-up queue: tick counter plus a circular queue in one RAM, kept sorted.
// Depends on swq_pkg and swq_ram.
// Sleep: S_INS_CMP shifts later entries up and writes the new one (S_INS_WR at the bottom); full: S_FIN.
// Tick: S_POP_LIM, then S_POP_CHK pops due entries; results 1/cycle while out_ready holds.
// One item at a time; in_ready returns with the final result, even while it still waits.
// Reset (synchronous, active low) clears the counter, occupancy and control; RAM keeps data.
module sorted_wakeup_queue
  import swq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic [7:0]           in_thread_id,
  input  logic signed [31:0]   in_sleep_ticks,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [7:0]           out_woken_id,
  output logic [TICK_W-1:0]    out_now_tick,
  output logic                 out_last
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_S  = (AW+1)'(QUEUE_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_INS_CMP = 6'b000010,
    S_INS_WR  = 6'b000100,
    S_POP_LIM = 6'b001000,
    S_POP_CHK = 6'b010000,
    S_FIN     = 6'b100000
  } state_t;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] x);
    return (x == LAST_IDX) ? '0 : AW'(x + 1'b1);
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] x);
    return (x == '0) ? LAST_IDX : AW'(x - 1'b1);
  endfunction

  state_t              state_r, state_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       p_r, p_nxt;
  logic [CW-1:0]       j_r, j_nxt;
  logic [WAKE_W-1:0]   wake_r, wake_nxt;
  logic [7:0]          id_r, id_nxt;
  logic [WAKE_W-1:0]   limit_r, limit_nxt;
  logic [POP_W-1:0]    popped_r, popped_nxt;
  logic                pend_r, pend_nxt;
  swq_status_t         fin_status_r, fin_status_nxt;
  logic [7:0]          fin_id_r, fin_id_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic [7:0]          out_id_r, out_id_nxt;
  logic [TICK_W-1:0]   out_tick_r, out_tick_nxt;
  logic                out_last_r, out_last_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  swq_entry_t          ram_wdata, ram_rdata;
  logic [AW:0]         tail_sum;
  logic [AW-1:0]       tail;
  logic                out_free, in_xfer, due;

  swq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign tail_sum = (AW+1)'(head_r) + (AW+1)'(count_r);
  assign tail     = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
  assign due      = (ram_rdata.wake <= limit_r);

  always_comb begin
    state_nxt      = state_r;
    tick_nxt       = tick_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    p_nxt          = p_r;
    j_nxt          = j_r;
    wake_nxt       = wake_r;
    id_nxt         = id_r;
    limit_nxt      = limit_r;
    popped_nxt     = popped_r;
    pend_nxt       = pend_r;
    fin_status_nxt = fin_status_r;
    fin_id_nxt     = fin_id_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_tick_nxt   = out_tick_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = p_r;
    ram_wdata      = '{wake: wake_r, id: id_r};
    ram_raddr      = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_kind) begin
            wake_nxt = {1'b0, tick_r} + {32'd0, ($unsigned(in_sleep_ticks) ^ BIAS32)};
            id_nxt   = in_thread_id;
            if (count_r == CW'(QUEUE_DEPTH)) begin
              fin_status_nxt = ST_FULL;
              fin_id_nxt     = '0;
              state_nxt      = S_FIN;
            end else begin
              p_nxt = tail;
              j_nxt = count_r;
              state_nxt = (count_r == '0) ? S_INS_WR : S_INS_CMP;
            end
          end else begin
            tick_nxt  = TICK_W'(tick_r + 1'b1);
            state_nxt = S_POP_LIM;
          end
        end
        ram_raddr = idx_dec(tail);
      end
      S_INS_CMP: begin
        ram_we = 1'b1;
        if (ram_rdata.wake <= wake_r) begin
          count_nxt      = CW'(count_r + 1'b1);
          fin_status_nxt = ST_ACCEPTED;
          fin_id_nxt     = '0;
          state_nxt      = S_FIN;
        end else begin
          ram_wdata = ram_rdata;
          p_nxt     = idx_dec(p_r);
          j_nxt     = CW'(j_r - 1'b1);
          if (j_r == CW'(1)) begin
            state_nxt = S_INS_WR;
          end
        end
        ram_raddr = idx_dec(p_nxt);
      end
      S_INS_WR: begin
        ram_we         = 1'b1;
        count_nxt      = CW'(count_r + 1'b1);
        fin_status_nxt = ST_ACCEPTED;
        fin_id_nxt     = '0;
        state_nxt      = S_FIN;
      end
      S_POP_LIM: begin
        limit_nxt  = {1'b0, tick_r} + BIAS;
        popped_nxt = '0;
        pend_nxt   = 1'b0;
        if (count_r == '0) begin
          fin_status_nxt = ST_NONE;
          fin_id_nxt     = '0;
          state_nxt      = S_FIN;
        end else begin
          state_nxt = S_POP_CHK;
        end
        ram_raddr = head_r;
      end
      S_POP_CHK: begin
        if (due) begin
          if (!pend_r || out_free) begin
            if (pend_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_WOKEN;
              out_id_nxt     = fin_id_r;
              out_tick_nxt   = tick_r;
              out_last_nxt   = 1'b0;
            end
            pend_nxt       = 1'b1;
            fin_status_nxt = ST_WOKEN;
            fin_id_nxt     = ram_rdata.id;
            head_nxt       = idx_inc(head_r);
            count_nxt      = CW'(count_r - 1'b1);
            popped_nxt     = POP_W'(popped_r + 1'b1);
            if (count_r == CW'(1) || popped_r == POP_W'(MAX_RESULTS - 1)) begin
              state_nxt = S_FIN;
            end
          end
        end else begin
          if (!pend_r) begin
            fin_status_nxt = ST_NONE;
            fin_id_nxt     = '0;
          end
          state_nxt = S_FIN;
        end
        ram_raddr = head_nxt;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = fin_status_r;
          out_id_nxt     = fin_id_r;
          out_tick_nxt   = tick_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      head_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r          <= p_nxt;
    j_r          <= j_nxt;
    wake_r       <= wake_nxt;
    id_r         <= id_nxt;
    limit_r      <= limit_nxt;
    popped_r     <= popped_nxt;
    fin_status_r <= fin_status_nxt;
    fin_id_r     <= fin_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_tick_r   <= out_tick_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_woken_id = out_id_r;
  assign out_now_tick = out_tick_r;
  assign out_last     = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_WOKEN) |-> out_last)
    else $error("single-result status without last");

  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_kind |=> tick_r == TICK_W'($past(tick_r) + 1'b1))
    else $error("tick counter did not advance on tick transfer");

  a_we_insert: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_INS_CMP || state_r == S_INS_WR))
    else $error("RAM write outside insertion");

  a_pop_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP_CHK |-> count_r != '0)
    else $error("pop scan on empty queue");
`endif

endmodule
